### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared types, codes and constants of the bounded lifo stack
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ACTION_W   = 3;
  localparam int WORD_W     = 32;
  localparam int POSITION_W = 5;
  localparam int STATUS_W   = 2;
  localparam int ENTRIES_W  = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [WORD_W-1:0] ERR_WORD  = 32'hFFFF_FFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_TOP    = 3'd3,
    ACT_BOTTOM = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_t;

  // per-cell control: store the broadcast word, or load own word into the read chain
  typedef struct packed {
    logic wr;
    logic sel;
  } cell_ctl_t;

endpackage

### rtl/bls_if.sv
// ----------------------------------------------------------------------------
// bls_req_if / bls_rsp_if
// valid/ready channels carrying stack requests and stack results
// ----------------------------------------------------------------------------
interface bls_req_if import bls_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [WORD_W-1:0]     value;
  logic [POSITION_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface bls_rsp_if import bls_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_W-1:0]     data;
  logic [STATUS_W-1:0]          status;
  logic                         is_full;
  logic                         is_empty;
  logic [ENTRIES_W-1:0]         entries;

  modport source (output valid, data, status, is_full, is_empty, entries, input ready);
  modport sink   (input valid, data, status, is_full, is_empty, entries, output ready);
endinterface

### rtl/bls_cell.sv
// ----------------------------------------------------------------------------
// bls_cell
// one stack entry plus one stage of the read chain toward cell 0 (the bottom cell)
// ----------------------------------------------------------------------------
module bls_cell import bls_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] wdata,
  input  logic [WORD_W-1:0] pass_in,
  output logic [WORD_W-1:0] pass_out
);

  logic [WORD_W-1:0] word;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      word <= wdata;
    end
    // selected cell drops its word into the chain, others forward the neighbor
    pass_out <= ctl.sel ? word : pass_in;
  end

endmodule

### rtl/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// bounded lifo stack of signed 32-bit words built as a row of entry cells
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req      in   valid/ready    action, value, position
// rsp      out  valid/ready    data, status, is_full, is_empty, entries
// cfg      in   cfg_we         cfg_wdata (capacity)
//
// push, errors and unknown actions: result registered, valid in the cycle after the item is taken
// reads (pop, peek, top, bottom) of entry k (0 = bottom): the read chain moves
// the word one cell per cycle down to cell 0, whose output is registered as the result
// one item in flight; req.ready is low while a read travels the chain
// a waiting result stalls req only until rsp.ready takes it
// rst empties the stack and sets capacity to 16; stored words are not cleared
// ----------------------------------------------------------------------------
module bounded_lifo_stack import bls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  bls_req_if.sink           req,
  bls_rsp_if.source         rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int EW = CW + CAP_W;

  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [CAP_W-1:0]  capacity;
  logic [IW-1:0]     remaining;

  logic              rsp_valid;
  logic [WORD_W-1:0] rsp_data;
  status_t           rsp_status;
  logic              rsp_full;
  logic              rsp_empty;
  logic [ENTRIES_W-1:0] rsp_entries;

  logic              accept;
  logic              in_ready;
  logic              sweep_done;

  logic [EW-1:0]     cnt_e, cap_e, eff_cap, pos_e, cnt_next_e;
  logic [CW-1:0]     count_next;
  logic [EW-1:0]     rd_idx_e;
  logic              need_read, push_go;
  logic [WORD_W-1:0] step_data;
  status_t           step_status;

  cell_ctl_t         ctl  [DEPTH];
  logic [WORD_W-1:0] pass [DEPTH];

  // ---------------- step decode ----------------
  always_comb begin
    cnt_e = EW'(count);
    cap_e = EW'(capacity);
    pos_e = EW'(req.position);
    if (cap_e == '0) begin
      eff_cap = EW'(1);
    end else if (cap_e > DEPTH_E) begin
      eff_cap = DEPTH_E;
    end else begin
      eff_cap = cap_e;
    end

    count_next  = count;
    rd_idx_e    = '0;
    need_read   = 1'b0;
    push_go     = 1'b0;
    step_data   = '0;
    step_status = ST_OK;

    case (action_t'(req.action))
      ACT_PUSH: begin
        if (cnt_e >= eff_cap || cnt_e >= DEPTH_E) begin
          step_status = ST_OVERFLOW;
          step_data   = ERR_WORD;
        end else begin
          push_go    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ACT_POP: begin
        if (count == '0) begin
          step_status = ST_UNDERFLOW;
          step_data   = ERR_WORD;
        end else begin
          need_read  = 1'b1;
          rd_idx_e   = cnt_e - EW'(1);
          count_next = count - CW'(1);
        end
      end
      ACT_PEEK: begin
        if (pos_e == '0 || pos_e > cnt_e) begin
          step_status = ST_BADPOS;
          step_data   = ERR_WORD;
        end else begin
          need_read = 1'b1;
          rd_idx_e  = cnt_e - pos_e;
        end
      end
      ACT_TOP, ACT_BOTTOM: begin
        if (count == '0) begin
          step_status = ST_UNDERFLOW;
          step_data   = ERR_WORD;
        end else begin
          need_read = 1'b1;
          rd_idx_e  = (action_t'(req.action) == ACT_TOP) ? cnt_e - EW'(1) : '0;
        end
      end
      default: begin
      end
    endcase

    cnt_next_e = EW'(count_next);
  end

  // ---------------- control fsm ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && need_read) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (remaining == '0) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    sweep_done = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rsp_valid || rsp.ready;
      end
      S_SWEEP: begin
        sweep_done = (remaining == '0);
      end
      default: begin
      end
    endcase
  end

  assign accept    = req.valid && in_ready;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= !need_read;
      end else if (sweep_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result fields are set when the item is taken; read data lands after the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data    <= step_data;
      rsp_status  <= step_status;
      rsp_full    <= (cnt_next_e >= eff_cap);
      rsp_empty   <= (count_next == '0);
      rsp_entries <= cnt_next_e[ENTRIES_W-1:0];
      remaining   <= rd_idx_e[IW-1:0];
    end else if (state == S_SWEEP) begin
      if (sweep_done) begin
        rsp_data <= pass[0];
      end else begin
        remaining <= remaining - IW'(1);
      end
    end
  end

  // ---------------- cell row ----------------
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_W-1:0] pass_in;

      assign ctl[gi].wr  = accept && push_go && (count[IW-1:0] == IW'(gi));
      assign ctl[gi].sel = accept && need_read && (rd_idx_e[IW-1:0] == IW'(gi));

      if (gi == DEPTH - 1) begin : g_last
        assign pass_in = '0;
      end else begin : g_mid
        assign pass_in = pass[gi+1];
      end

      bls_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[gi]),
        .wdata    (req.value),
        .pass_in  (pass_in),
        .pass_out (pass[gi])
      );
    end
  endgenerate

  assign rsp.valid    = rsp_valid;
  assign rsp.data     = rsp_data;
  assign rsp.status   = rsp_status;
  assign rsp.is_full  = rsp_full;
  assign rsp.is_empty = rsp_empty;
  assign rsp.entries  = rsp_entries;

endmodule
